>>> rtl/mmvp_pkg.sv
// shared types, constants and mode codes for the median motion vector predictor
package mmvp_pkg;

    localparam int VEC_COMPONENT_BITS = 16;
    localparam int REF_BITS           = 6;
    localparam int TGT_BITS           = 5;
    localparam int VEC_BITS           = 32;
    localparam int HALF_BITS          = 16;
    localparam int OUT_BITS           = 16;

    localparam logic signed [REF_BITS-1:0] REF_UNAVAIL = -6'sd2;
    localparam logic signed [REF_BITS-1:0] REF_INTRA   = -6'sd1;

    typedef logic signed [VEC_COMPONENT_BITS-1:0] comp_t;

    typedef enum logic [1:0] {
        MODE_MEDIAN = 2'd0,
        MODE_16X8   = 2'd1,
        MODE_8X16   = 2'd2,
        MODE_SKIP   = 2'd3
    } mode_t;

    typedef struct packed {
        logic signed [REF_BITS-1:0] ref_idx;
        comp_t                      x;
        comp_t                      y;
    } nbr_t;

endpackage

>>> rtl/mmvp_nbr.sv
// neighbour decode: reference clamp and vector component extraction
module mmvp_nbr
(
    input  logic signed [mmvp_pkg::REF_BITS-1:0] ref_in,
    input  logic        [mmvp_pkg::VEC_BITS-1:0] vec_in,
    output mmvp_pkg::nbr_t                       nbr
);

    always_comb
    begin
        // anything below unavailable counts as unavailable
        if (ref_in < mmvp_pkg::REF_UNAVAIL)
        begin
            nbr.ref_idx = mmvp_pkg::REF_UNAVAIL;
        end
        else
        begin
            nbr.ref_idx = ref_in;
        end
        // no vector for intra or unavailable neighbours
        if (ref_in[mmvp_pkg::REF_BITS-1])
        begin
            nbr.x = '0;
            nbr.y = '0;
        end
        else
        begin
            nbr.x = vec_in[mmvp_pkg::VEC_COMPONENT_BITS-1:0];
            nbr.y = vec_in[mmvp_pkg::HALF_BITS +: mmvp_pkg::VEC_COMPONENT_BITS];
        end
    end

endmodule

>>> rtl/mmvp_pred.sv
// predictor selection: directional shortcuts, skip zero rules and median
module mmvp_pred
(
    input  mmvp_pkg::nbr_t                 nbr_a,
    input  mmvp_pkg::nbr_t                 nbr_b,
    input  mmvp_pkg::nbr_t                 nbr_c0,
    input  mmvp_pkg::nbr_t                 nbr_d,
    input  logic [mmvp_pkg::TGT_BITS-1:0]  target_ref,
    input  logic [1:0]                     pred_mode,
    input  logic                           part_select,
    output mmvp_pkg::comp_t                px,
    output mmvp_pkg::comp_t                py
);

    function automatic mmvp_pkg::comp_t median3(
        input mmvp_pkg::comp_t a,
        input mmvp_pkg::comp_t b,
        input mmvp_pkg::comp_t c
    );
        mmvp_pkg::comp_t lo;
        mmvp_pkg::comp_t hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c < lo)
        begin
            return lo;
        end
        else if (c > hi)
        begin
            return hi;
        end
        return c;
    endfunction

    function automatic logic skip_zero(input mmvp_pkg::nbr_t n);
        return (n.ref_idx == mmvp_pkg::REF_UNAVAIL) ||
               (n.ref_idx == '0 && n.x == '0 && n.y == '0);
    endfunction

    mmvp_pkg::nbr_t                      nbr_c;
    mmvp_pkg::nbr_t                      shortcut;
    mmvp_pkg::mode_t                     mode;
    logic signed [mmvp_pkg::REF_BITS-1:0] tgt;
    logic                                match_a;
    logic                                match_b;
    logic                                match_c;
    logic                                single;
    logic                                done;
    logic                                zero;
    mmvp_pkg::comp_t                     gen_x;
    mmvp_pkg::comp_t                     gen_y;

    assign mode  = mmvp_pkg::mode_t'(pred_mode);
    assign nbr_c = (nbr_c0.ref_idx == mmvp_pkg::REF_UNAVAIL) ? nbr_d : nbr_c0;

    // skip mode predicts against reference zero
    assign tgt = (mode == mmvp_pkg::MODE_SKIP) ? '0 : $signed({1'b0, target_ref});

    assign match_a = (nbr_a.ref_idx == tgt);
    assign match_b = (nbr_b.ref_idx == tgt);
    assign match_c = (nbr_c.ref_idx == tgt);
    assign single  = (match_a ^ match_b ^ match_c) & ~(match_a & match_b & match_c);

    always_comb
    begin
        if (nbr_b.ref_idx == mmvp_pkg::REF_UNAVAIL &&
            nbr_c.ref_idx == mmvp_pkg::REF_UNAVAIL &&
            nbr_a.ref_idx != mmvp_pkg::REF_UNAVAIL)
        begin
            gen_x = nbr_a.x;
            gen_y = nbr_a.y;
        end
        else if (single)
        begin
            gen_x = match_a ? nbr_a.x : (match_b ? nbr_b.x : nbr_c.x);
            gen_y = match_a ? nbr_a.y : (match_b ? nbr_b.y : nbr_c.y);
        end
        else
        begin
            gen_x = median3(nbr_a.x, nbr_b.x, nbr_c.x);
            gen_y = median3(nbr_a.y, nbr_b.y, nbr_c.y);
        end
    end

    always_comb
    begin
        shortcut = nbr_a;
        done     = 1'b0;
        zero     = 1'b0;
        case (mode)
            mmvp_pkg::MODE_16X8:
            begin
                shortcut = part_select ? nbr_a : nbr_b;
                done     = (shortcut.ref_idx == tgt);
            end
            mmvp_pkg::MODE_8X16:
            begin
                shortcut = part_select ? nbr_c : nbr_a;
                done     = (shortcut.ref_idx == tgt);
            end
            mmvp_pkg::MODE_SKIP:
            begin
                zero = skip_zero(nbr_a) || skip_zero(nbr_b);
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (zero)
        begin
            px = '0;
            py = '0;
        end
        else if (done)
        begin
            px = shortcut.x;
            py = shortcut.y;
        end
        else
        begin
            px = gen_x;
            py = gen_y;
        end
    end

endmodule

>>> rtl/median_mv_predictor.sv
// top level: request register, neighbour decode, predictor and result register
//
// One request carries four neighbours (reference index and packed vector),
// the target reference, the prediction mode and the partition select, and
// returns one predicted vector (pred_x, pred_y).
// Both channels use valid/ready; a request or result moves when both are high.
// The request is registered in the request register, then decoded and resolved
// in one pass of logic; the result is held in an output register, and out_valid
// rises when that register takes the result.
// Throughput is one request per cycle while the receiver does not stall; a new
// request is taken while a result waits, as long as the request register is
// empty or can drain into the result register.
// When the receiver stalls, the result register holds and one more request
// waits in the request register, after which in_ready falls.
// Reset empties both registers; in_ready is high right after reset.
module median_mv_predictor
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [mmvp_pkg::REF_BITS-1:0]  ref_left,
    input  logic signed [mmvp_pkg::REF_BITS-1:0]  ref_top,
    input  logic signed [mmvp_pkg::REF_BITS-1:0]  ref_topright,
    input  logic signed [mmvp_pkg::REF_BITS-1:0]  ref_topleft,
    input  logic        [mmvp_pkg::VEC_BITS-1:0]  vec_left,
    input  logic        [mmvp_pkg::VEC_BITS-1:0]  vec_top,
    input  logic        [mmvp_pkg::VEC_BITS-1:0]  vec_topright,
    input  logic        [mmvp_pkg::VEC_BITS-1:0]  vec_topleft,
    input  logic        [mmvp_pkg::TGT_BITS-1:0]  target_ref,
    input  logic        [1:0]                     pred_mode,
    input  logic                                  part_select,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [mmvp_pkg::OUT_BITS-1:0]  pred_x,
    output logic signed [mmvp_pkg::OUT_BITS-1:0]  pred_y
);

    logic                                  s1_valid_reg;
    logic signed [mmvp_pkg::REF_BITS-1:0]  ref_left_reg;
    logic signed [mmvp_pkg::REF_BITS-1:0]  ref_top_reg;
    logic signed [mmvp_pkg::REF_BITS-1:0]  ref_topright_reg;
    logic signed [mmvp_pkg::REF_BITS-1:0]  ref_topleft_reg;
    logic        [mmvp_pkg::VEC_BITS-1:0]  vec_left_reg;
    logic        [mmvp_pkg::VEC_BITS-1:0]  vec_top_reg;
    logic        [mmvp_pkg::VEC_BITS-1:0]  vec_topright_reg;
    logic        [mmvp_pkg::VEC_BITS-1:0]  vec_topleft_reg;
    logic        [mmvp_pkg::TGT_BITS-1:0]  target_ref_reg;
    logic        [1:0]                     pred_mode_reg;
    logic                                  part_select_reg;
    logic                                  out_valid_reg;
    logic signed [mmvp_pkg::OUT_BITS-1:0]  pred_x_reg;
    logic signed [mmvp_pkg::OUT_BITS-1:0]  pred_y_reg;
    logic signed [mmvp_pkg::OUT_BITS-1:0]  pred_x_next;
    logic signed [mmvp_pkg::OUT_BITS-1:0]  pred_y_next;

    logic            out_take;
    logic            in_take;
    mmvp_pkg::nbr_t  nbr_a;
    mmvp_pkg::nbr_t  nbr_b;
    mmvp_pkg::nbr_t  nbr_c0;
    mmvp_pkg::nbr_t  nbr_d;
    mmvp_pkg::comp_t px;
    mmvp_pkg::comp_t py;

    assign out_take  = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || out_take;
    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign pred_x    = pred_x_reg;
    assign pred_y    = pred_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_take)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ref_left_reg     <= ref_left;
            ref_top_reg      <= ref_top;
            ref_topright_reg <= ref_topright;
            ref_topleft_reg  <= ref_topleft;
            vec_left_reg     <= vec_left;
            vec_top_reg      <= vec_top;
            vec_topright_reg <= vec_topright;
            vec_topleft_reg  <= vec_topleft;
            target_ref_reg   <= target_ref;
            pred_mode_reg    <= pred_mode;
            part_select_reg  <= part_select;
        end
    end

    mmvp_nbr u_nbr_a (.ref_in(ref_left_reg),     .vec_in(vec_left_reg),     .nbr(nbr_a));
    mmvp_nbr u_nbr_b (.ref_in(ref_top_reg),      .vec_in(vec_top_reg),      .nbr(nbr_b));
    mmvp_nbr u_nbr_c (.ref_in(ref_topright_reg), .vec_in(vec_topright_reg), .nbr(nbr_c0));
    mmvp_nbr u_nbr_d (.ref_in(ref_topleft_reg),  .vec_in(vec_topleft_reg),  .nbr(nbr_d));

    mmvp_pred u_pred
    (
        .nbr_a       (nbr_a),
        .nbr_b       (nbr_b),
        .nbr_c0      (nbr_c0),
        .nbr_d       (nbr_d),
        .target_ref  (target_ref_reg),
        .pred_mode   (pred_mode_reg),
        .part_select (part_select_reg),
        .px          (px),
        .py          (py)
    );

    // cast to the output width, which equals the component width
    assign pred_x_next = mmvp_pkg::OUT_BITS'(px);
    assign pred_y_next = mmvp_pkg::OUT_BITS'(py);

    always_ff @(posedge clk)
    begin
        if (out_take && s1_valid_reg)
        begin
            pred_x_reg <= pred_x_next;
            pred_y_reg <= pred_y_next;
        end
    end

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted request not held in request register");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("request accepted while both registers are full");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_take) |=> out_valid_reg)
        else $error("request register did not move into result register");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("in_ready low with an empty request register");

endmodule

>>> dv/median_mv_predictor_checker.sv
`timescale 1ns / 1ps
// result checker: predicts the vector for each accepted request and compares returned results
module median_mv_predictor_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic signed [mmvp_pkg::REF_BITS-1:0]  ref_left,
    input  logic signed [mmvp_pkg::REF_BITS-1:0]  ref_top,
    input  logic signed [mmvp_pkg::REF_BITS-1:0]  ref_topright,
    input  logic signed [mmvp_pkg::REF_BITS-1:0]  ref_topleft,
    input  logic        [mmvp_pkg::VEC_BITS-1:0]  vec_left,
    input  logic        [mmvp_pkg::VEC_BITS-1:0]  vec_top,
    input  logic        [mmvp_pkg::VEC_BITS-1:0]  vec_topright,
    input  logic        [mmvp_pkg::VEC_BITS-1:0]  vec_topleft,
    input  logic        [mmvp_pkg::TGT_BITS-1:0]  target_ref,
    input  logic        [1:0]                     pred_mode,
    input  logic                                  part_select,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [mmvp_pkg::OUT_BITS-1:0]  pred_x,
    input  logic signed [mmvp_pkg::OUT_BITS-1:0]  pred_y,
    output int                                    fail_count,
    output int                                    outstanding
);

    typedef struct {
        logic signed [mmvp_pkg::OUT_BITS-1:0] x;
        logic signed [mmvp_pkg::OUT_BITS-1:0] y;
    } mv_t;

    mv_t expected_mv_q[$];

    function automatic mmvp_pkg::nbr_t decode_nbr(
        logic signed [mmvp_pkg::REF_BITS-1:0] ref_in,
        logic [mmvp_pkg::VEC_BITS-1:0] vec_in);
        mmvp_pkg::nbr_t n;
        n.ref_idx = (ref_in < mmvp_pkg::REF_UNAVAIL) ? mmvp_pkg::REF_UNAVAIL : ref_in;
        n.x = '0;
        n.y = '0;
        if (ref_in >= 0)
        begin
            n.x = vec_in[mmvp_pkg::VEC_COMPONENT_BITS-1:0];
            n.y = vec_in[mmvp_pkg::HALF_BITS +: mmvp_pkg::VEC_COMPONENT_BITS];
        end
        return n;
    endfunction

    function automatic mv_t copy_mv(mmvp_pkg::nbr_t n);
        mv_t m;
        m.x = $signed(n.x);
        m.y = $signed(n.y);
        return m;
    endfunction

    function automatic int median3(int a, int b, int c);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c < lo)
            return lo;
        if (c > hi)
            return hi;
        return c;
    endfunction

    function automatic bit skip_forces_zero(mmvp_pkg::nbr_t n);
        return n.ref_idx == mmvp_pkg::REF_UNAVAIL ||
               ($signed(n.ref_idx) == 0 && n.x == '0 && n.y == '0);
    endfunction

    function automatic mv_t resolve_general(mmvp_pkg::nbr_t a, mmvp_pkg::nbr_t b,
                                            mmvp_pkg::nbr_t c, int tgt);
        mv_t m;
        int hits;
        if (b.ref_idx == mmvp_pkg::REF_UNAVAIL && c.ref_idx == mmvp_pkg::REF_UNAVAIL &&
            $signed(a.ref_idx) >= mmvp_pkg::REF_INTRA)
            return copy_mv(a);
        hits = 0;
        if ($signed(a.ref_idx) == tgt)
            hits++;
        if ($signed(b.ref_idx) == tgt)
            hits++;
        if ($signed(c.ref_idx) == tgt)
            hits++;
        if (hits == 1)
        begin
            if ($signed(a.ref_idx) == tgt)
                return copy_mv(a);
            if ($signed(b.ref_idx) == tgt)
                return copy_mv(b);
            return copy_mv(c);
        end
        m.x = mmvp_pkg::OUT_BITS'(median3($signed(a.x), $signed(b.x), $signed(c.x)));
        m.y = mmvp_pkg::OUT_BITS'(median3($signed(a.y), $signed(b.y), $signed(c.y)));
        return m;
    endfunction

    function automatic mv_t predict_mv(logic signed [mmvp_pkg::REF_BITS-1:0] l_ref,
                                       logic signed [mmvp_pkg::REF_BITS-1:0] t_ref,
                                       logic signed [mmvp_pkg::REF_BITS-1:0] tr_ref,
                                       logic signed [mmvp_pkg::REF_BITS-1:0] tl_ref,
                                       logic [mmvp_pkg::VEC_BITS-1:0] l_vec,
                                       logic [mmvp_pkg::VEC_BITS-1:0] t_vec,
                                       logic [mmvp_pkg::VEC_BITS-1:0] tr_vec,
                                       logic [mmvp_pkg::VEC_BITS-1:0] tl_vec,
                                       logic [mmvp_pkg::TGT_BITS-1:0] tgt_ref,
                                       logic [1:0] mode_bits,
                                       logic part);
        mmvp_pkg::nbr_t a;
        mmvp_pkg::nbr_t b;
        mmvp_pkg::nbr_t c;
        mmvp_pkg::nbr_t d;
        mmvp_pkg::nbr_t s;
        mv_t zero_mv;
        int tgt;
        a = decode_nbr(l_ref, l_vec);
        b = decode_nbr(t_ref, t_vec);
        c = decode_nbr(tr_ref, tr_vec);
        d = decode_nbr(tl_ref, tl_vec);
        if (c.ref_idx == mmvp_pkg::REF_UNAVAIL)
            c = d;
        tgt = tgt_ref;
        zero_mv.x = '0;
        zero_mv.y = '0;
        case (mmvp_pkg::mode_t'(mode_bits))
            mmvp_pkg::MODE_16X8:
            begin
                s = part ? a : b;
                if ($signed(s.ref_idx) == tgt)
                    return copy_mv(s);
            end
            mmvp_pkg::MODE_8X16:
            begin
                s = part ? c : a;
                if ($signed(s.ref_idx) == tgt)
                    return copy_mv(s);
            end
            mmvp_pkg::MODE_SKIP:
            begin
                tgt = 0;
                if (skip_forces_zero(a) || skip_forces_zero(b))
                    return zero_mv;
            end
            default: ;
        endcase
        return resolve_general(a, b, c, tgt);
    endfunction

    always @(posedge clk)
    begin : monitor
        mv_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_mv_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: x=%0d y=%0d", pred_x, pred_y);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_mv_q.pop_front();
                    if (pred_x !== want.x || pred_y !== want.y)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                                     want.x, want.y, pred_x, pred_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_mv_q.push_back(predict_mv(ref_left, ref_top, ref_topright,
                                                   ref_topleft, vec_left, vec_top,
                                                   vec_topright, vec_topleft, target_ref,
                                                   pred_mode, part_select));
            outstanding <= expected_mv_q.size();
        end
    end

endmodule

>>> dv/median_mv_predictor_test.sv
`timescale 1ns / 1ps
// testbench top: drives requests in bursts against a stalling receiver and gives the verdict
module median_mv_predictor_test;

    localparam int RANDOM_REQUESTS = 1900;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 600;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_ready;
    logic signed [mmvp_pkg::REF_BITS-1:0]  ref_left;
    logic signed [mmvp_pkg::REF_BITS-1:0]  ref_top;
    logic signed [mmvp_pkg::REF_BITS-1:0]  ref_topright;
    logic signed [mmvp_pkg::REF_BITS-1:0]  ref_topleft;
    logic        [mmvp_pkg::VEC_BITS-1:0]  vec_left;
    logic        [mmvp_pkg::VEC_BITS-1:0]  vec_top;
    logic        [mmvp_pkg::VEC_BITS-1:0]  vec_topright;
    logic        [mmvp_pkg::VEC_BITS-1:0]  vec_topleft;
    logic        [mmvp_pkg::TGT_BITS-1:0]  target_ref;
    logic        [1:0]                     pred_mode;
    logic                                  part_select;
    logic                                  out_valid;
    logic                                  out_ready;
    logic signed [mmvp_pkg::OUT_BITS-1:0]  pred_x;
    logic signed [mmvp_pkg::OUT_BITS-1:0]  pred_y;

    int fail_count;
    int outstanding;
    int requests_sent;
    int burst_left;
    int cycle_count;

    median_mv_predictor uut (.*);

    median_mv_predictor_checker mv_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [mmvp_pkg::HALF_BITS-1:0] rand_half();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return mmvp_pkg::HALF_BITS'($urandom_range(0, 8) - 4);
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return mmvp_pkg::HALF_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [mmvp_pkg::VEC_BITS-1:0] rand_vec();
        if ($urandom_range(0, 4) == 0)
            return '0;
        return {rand_half(), rand_half()};
    endfunction

    function automatic logic signed [mmvp_pkg::REF_BITS-1:0] rand_ref(
        logic [mmvp_pkg::TGT_BITS-1:0] hint);
        case ($urandom_range(0, 9))
            0: return mmvp_pkg::REF_UNAVAIL;
            1: return mmvp_pkg::REF_INTRA;
            2, 3, 4: return {1'b0, hint};
            5: return mmvp_pkg::REF_BITS'($urandom_range(0, 3));
            6: return mmvp_pkg::REF_BITS'($urandom());
            default: return mmvp_pkg::REF_BITS'($urandom_range(0, 31));
        endcase
    endfunction

    task automatic offer_request(input logic signed [mmvp_pkg::REF_BITS-1:0] rl,
                                 input logic signed [mmvp_pkg::REF_BITS-1:0] rt,
                                 input logic signed [mmvp_pkg::REF_BITS-1:0] rtr,
                                 input logic signed [mmvp_pkg::REF_BITS-1:0] rtl,
                                 input logic [mmvp_pkg::VEC_BITS-1:0] vl,
                                 input logic [mmvp_pkg::VEC_BITS-1:0] vt,
                                 input logic [mmvp_pkg::VEC_BITS-1:0] vtr,
                                 input logic [mmvp_pkg::VEC_BITS-1:0] vtl,
                                 input logic [mmvp_pkg::TGT_BITS-1:0] tgt,
                                 input mmvp_pkg::mode_t mode,
                                 input logic part);
        int gap;
        ref_left     <= rl;
        ref_top      <= rt;
        ref_topright <= rtr;
        ref_topleft  <= rtl;
        vec_left     <= vl;
        vec_top      <= vt;
        vec_topright <= vtr;
        vec_topleft  <= vtl;
        target_ref   <= tgt;
        pred_mode    <= mode;
        part_select  <= part;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // random ready patterns, and one long hold-off so the request side backs up
    initial
    begin : receiver
        int pattern;
        int span;
        int k;
        bit held_off;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held_off && requests_sent >= HOLD_OFF_AFTER)
            begin
                held_off = 1'b1;
                repeat (HOLD_OFF_CYCLES)
                begin
                    @(posedge clk);
                    out_ready <= 1'b0;
                end
            end
            pattern = $urandom_range(0, 3);
            span = $urandom_range(4, 80);
            for (k = 0; k < span; k++)
            begin
                @(posedge clk);
                case (pattern)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 4) == 0);
                    default: out_ready <= (k % 3 != 2);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int n;
        logic [mmvp_pkg::TGT_BITS-1:0] tgt;
        logic [mmvp_pkg::TGT_BITS-1:0] hint;
        mmvp_pkg::mode_t mode;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        ref_left     <= '0;
        ref_top      <= '0;
        ref_topright <= '0;
        ref_topleft  <= '0;
        vec_left     <= '0;
        vec_top      <= '0;
        vec_topright <= '0;
        vec_topleft  <= '0;
        target_ref   <= '0;
        pred_mode    <= '0;
        part_select  <= 1'b0;
        burst_left   = $urandom_range(1, 30);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // nothing available
        offer_request(mmvp_pkg::REF_UNAVAIL, mmvp_pkg::REF_UNAVAIL, mmvp_pkg::REF_UNAVAIL,
                      mmvp_pkg::REF_UNAVAIL, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                      32'hF0F0_F0F0, 0, mmvp_pkg::MODE_MEDIAN, 1'b0);
        // left only, with and without a vector
        offer_request(0, mmvp_pkg::REF_UNAVAIL, mmvp_pkg::REF_UNAVAIL, mmvp_pkg::REF_UNAVAIL,
                      32'h8000_7FFF, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 5,
                      mmvp_pkg::MODE_MEDIAN, 1'b0);
        offer_request(mmvp_pkg::REF_INTRA, mmvp_pkg::REF_UNAVAIL, mmvp_pkg::REF_UNAVAIL,
                      mmvp_pkg::REF_UNAVAIL, 32'hDEAD_BEEF, 32'h1111_1111, 32'h2222_2222,
                      32'h3333_3333, 5, mmvp_pkg::MODE_MEDIAN, 1'b1);
        // single match, then full median on extremes, then median with no match
        offer_request(1, 3, 2, 0, 32'h0001_0002, 32'hFFFE_0005, 32'h0007_0008,
                      32'h0009_000A, 3, mmvp_pkg::MODE_MEDIAN, 1'b0);
        offer_request(7, 7, 7, 7, 32'h8000_8000, 32'h7FFF_7FFF, 32'h0001_FFFF,
                      32'h4444_4444, 7, mmvp_pkg::MODE_MEDIAN, 1'b0);
        offer_request(1, 2, 4, mmvp_pkg::REF_UNAVAIL, 32'h0010_FFF0, 32'hFFF0_0010,
                      32'h0003_0003, 32'h0, 9, mmvp_pkg::MODE_MEDIAN, 1'b1);
        // top-right replaced by top-left, also from refs below minus two; then a top ref below minus two
        offer_request(4, 5, mmvp_pkg::REF_UNAVAIL, 9, 32'h0005_0005, 32'h0006_0006,
                      32'h7777_7777, 32'h0102_0304, 9, mmvp_pkg::MODE_MEDIAN, 1'b0);
        offer_request(4, 5, -32, 9, 32'h0005_0005, 32'h0006_0006, 32'h7777_7777,
                      32'hFEDC_BA98, 9, mmvp_pkg::MODE_MEDIAN, 1'b0);
        offer_request(0, -3, 6, 1, 32'h00AA_00BB, 32'h1234_4321, 32'h0, 32'h0, 0,
                      mmvp_pkg::MODE_MEDIAN, 1'b0);
        // 16x8 shortcuts
        offer_request(2, 6, 3, 1, 32'h0011_0022, 32'h0033_0044, 32'h0055_0066,
                      32'h0077_0088, 6, mmvp_pkg::MODE_16X8, 1'b0);
        offer_request(6, 2, 6, 1, 32'h0011_0022, 32'h0033_0044, 32'h0055_0066,
                      32'h0077_0088, 6, mmvp_pkg::MODE_16X8, 1'b0);
        offer_request(6, 2, 3, 1, 32'hFF11_0022, 32'h0033_0044, 32'h0055_0066,
                      32'h0077_0088, 6, mmvp_pkg::MODE_16X8, 1'b1);
        offer_request(2, 6, 3, 1, 32'h0011_0022, 32'h0033_0044, 32'h0055_0066,
                      32'h0077_0088, 6, mmvp_pkg::MODE_16X8, 1'b1);
        // 8x16 shortcuts
        offer_request(8, 2, 3, 1, 32'h0101_0202, 32'h0303_0404, 32'h0505_0606,
                      32'h0707_0808, 8, mmvp_pkg::MODE_8X16, 1'b0);
        offer_request(2, 8, 8, 1, 32'h0101_0202, 32'h0303_0404, 32'h0505_0606,
                      32'h0707_0808, 8, mmvp_pkg::MODE_8X16, 1'b1);
        offer_request(2, 3, mmvp_pkg::REF_UNAVAIL, 8, 32'h0101_0202, 32'h0303_0404,
                      32'h0505_0606, 32'h8707_F808, 8, mmvp_pkg::MODE_8X16, 1'b1);
        offer_request(2, 3, 4, 8, 32'h0101_0202, 32'h0303_0404, 32'h0505_0606,
                      32'h0707_0808, 8, mmvp_pkg::MODE_8X16, 1'b1);
        // skip: unavailable neighbour, zero vector on ref 0, then general with target 0
        offer_request(mmvp_pkg::REF_UNAVAIL, 0, 0, 0, 32'h0, 32'h0005_0005, 32'h0006_0006,
                      32'h0007_0007, 12, mmvp_pkg::MODE_SKIP, 1'b0);
        offer_request(1, 0, 0, 0, 32'h0002_0002, 32'h0, 32'h0006_0006,
                      32'h0007_0007, 12, mmvp_pkg::MODE_SKIP, 1'b1);
        offer_request(0, 0, 3, 0, 32'h0, 32'h0001_0000, 32'h0006_0006,
                      32'h0007_0007, 31, mmvp_pkg::MODE_SKIP, 1'b0);
        offer_request(0, 1, 2, 0, 32'h0004_FFFC, 32'h0001_0000, 32'h0006_0006,
                      32'h0007_0007, 31, mmvp_pkg::MODE_SKIP, 1'b0);
        offer_request(mmvp_pkg::REF_INTRA, mmvp_pkg::REF_INTRA, mmvp_pkg::REF_UNAVAIL, 0,
                      32'hFFFF_FFFF, 32'h8000_0001, 32'h0, 32'h0009_0009, 0,
                      mmvp_pkg::MODE_SKIP, 1'b0);
        // top of the reference range with all-ones vectors
        offer_request(31, 31, 5, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_8000,
                      32'hFFFF_FFFF, 31, mmvp_pkg::MODE_MEDIAN, 1'b1);
        // intra neighbours ignore their vectors, and the top neighbour is the single match
        offer_request(mmvp_pkg::REF_INTRA, 3, mmvp_pkg::REF_INTRA, 2, 32'h7FFF_7FFF,
                      32'h0040_FFC0, 32'h8000_8000, 32'h0, 3, mmvp_pkg::MODE_MEDIAN, 1'b0);

        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            mode = mmvp_pkg::mode_t'($urandom_range(0, 3));
            tgt = ($urandom_range(0, 3) == 0) ? mmvp_pkg::TGT_BITS'($urandom_range(0, 31))
                                              : mmvp_pkg::TGT_BITS'($urandom_range(0, 3));
            hint = (mode == mmvp_pkg::MODE_SKIP && $urandom_range(0, 3) != 0) ? '0 : tgt;
            offer_request(rand_ref(hint), rand_ref(hint), rand_ref(hint), rand_ref(hint),
                          rand_vec(), rand_vec(), rand_vec(), rand_vec(), tgt, mode,
                          1'($urandom_range(0, 1)));
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
